### hw/rtl/prrs_pkg.sv
package prrs_pkg;

    // Default sizes of the thread and level tables.
    localparam int NUM_THREADS_DEF = 16;
    localparam int NUM_LEVELS_DEF  = 8;

    // Width of a level number as it travels between modules (covers 256 levels).
    localparam int LVL_MAX_W = 8;

    // Operation codes of an input beat.
    typedef enum logic [1:0] {
        FN_ACTIVATE = 2'd0,
        FN_SUSPEND  = 2'd1,
        FN_TICK     = 2'd2,
        FN_SETPRI   = 2'd3
    } func_t;

    // Status codes of a result beat.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DOUBLE   = 2'd1,
        ST_UNQUEUED = 2'd2
    } status_t;

    // Set or clear the occupancy bit of one level.
    typedef struct packed {
        logic                 en;
        logic [LVL_MAX_W-1:0] lvl;
        logic                 val;
    } lvl_upd_t;

    // Start a downward search below a level.
    typedef struct packed {
        logic                 start;
        logic [LVL_MAX_W-1:0] from;
    } scan_cmd_t;

    // Search result and summary occupancy.
    typedef struct packed {
        logic                 done;
        logic                 found;
        logic [LVL_MAX_W-1:0] lvl;
        logic                 any;
    } scan_res_t;

endpackage

### hw/rtl/prrs_lvl_track.sv
module prrs_lvl_track #(
    parameter int NUM_LEVELS = prrs_pkg::NUM_LEVELS_DEF,
    localparam int LW = $clog2(NUM_LEVELS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  prrs_pkg::lvl_upd_t  upd,
    input  prrs_pkg::scan_cmd_t scan,
    input  logic [LW-1:0]       q_lvl,
    output logic                q_bit,
    output prrs_pkg::scan_res_t scan_res
);
    import prrs_pkg::*;

    logic [NUM_LEVELS-1:0] nonempty_reg;
    logic                  busy_reg;
    logic [LW-1:0]         idx_reg;
    logic [LW-1:0]         idx_dec;
    logic                  hit;
    logic                  at_bottom;

    // One level below the search pointer is examined per cycle.
    assign idx_dec   = idx_reg - 1'b1;
    assign at_bottom = (idx_reg == '0);
    assign hit       = nonempty_reg[idx_dec];

    assign q_bit          = nonempty_reg[q_lvl];
    assign scan_res.done  = busy_reg && (at_bottom || hit);
    assign scan_res.found = busy_reg && !at_bottom && hit;
    assign scan_res.lvl   = LVL_MAX_W'(idx_dec);
    assign scan_res.any   = |nonempty_reg;

    // Occupancy bits and the search pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            if (upd.en)
            begin
                nonempty_reg[LW'(upd.lvl)] <= upd.val;
            end
            if (scan.start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= LW'(scan.from);
            end
            else if (scan_res.done)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_dec;
            end
        end
    end

endmodule

### hw/rtl/priority_round_robin_scheduler.sv
// Channel  Direction  Handshake             Fields
// in       to block   in_valid / in_stall   func, thread_id, new_priority
// out      from block out_valid / out_stall current_thread, current_level, is_idle, status
//
// One operation is worked at a time; in_stall is high until its result is registered.
// Error beats and ticks while idle only fetch the result; a timer tick also rotates the head,
// and activate, suspend and set priority (of a queued thread) work in link memory
// read-modify-write steps. Emptying the served level adds a downward search for the next
// occupied level. Reset clears control state and occupancy bits at once.
// The output register holds a stalled result while the next beat is accepted and worked.
module priority_round_robin_scheduler #(
    parameter int NUM_THREADS = prrs_pkg::NUM_THREADS_DEF,
    parameter int NUM_LEVELS  = prrs_pkg::NUM_LEVELS_DEF,
    localparam int TW = $clog2(NUM_THREADS),
    localparam int LW = $clog2(NUM_LEVELS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    func,
    input  logic [TW-1:0] thread_id,
    input  logic [LW-1:0] new_priority,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [TW-1:0] current_thread,
    output logic [LW-1:0] current_level,
    output logic          is_idle,
    output logic [1:0]    status
);
    import prrs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_TICK_WR,
        S_LO_START,
        S_LO_HEAD,
        S_LO_RDN,
        S_LO_WRN,
        S_LO_SCAN,
        S_LO_DONE,
        S_LI_START,
        S_LI_RDH,
        S_LI_RDHW,
        S_LI_RDTW,
        S_LI_WRH,
        S_LI_WRT,
        S_LI_DONE,
        S_FIN,
        S_OUT
    } state_t;

    // One entry of the thread memory: level and ring links.
    typedef struct packed {
        logic [LW-1:0] lvl;
        logic [TW-1:0] nxt;
        logic [TW-1:0] prv;
    } tword_t;

    state_t           state_reg, state_next;
    func_t            func_reg, func_next;
    status_t          status_reg, status_next;
    logic [TW-1:0]    tid_reg, tid_next;
    logic [LW-1:0]    np_reg, np_next;
    logic [LW-1:0]    lv_reg, lv_next;
    logic [TW-1:0]    n_reg, n_next;
    logic [TW-1:0]    p_reg, p_next;
    logic [TW-1:0]    h_reg, h_next;
    logic [TW-1:0]    tail_reg, tail_next;
    tword_t           hw_reg, hw_next;
    logic [LW-1:0]    serving_reg, serving_next;
    logic             idle_reg, idle_next;
    logic [NUM_THREADS-1:0] queued_reg, queued_next;
    logic [NUM_THREADS-1:0] lvl_valid_reg, lvl_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [TW-1:0]    cur_thread_reg, cur_thread_next;
    logic [LW-1:0]    cur_level_reg, cur_level_next;
    logic             is_idle_reg, is_idle_next;
    status_t          status_out_reg, status_out_next;

    // Thread memory and level head memory.
    tword_t           thread_mem [NUM_THREADS];
    logic [TW-1:0]    head_mem [NUM_LEVELS];
    tword_t           tm_rdata_reg;
    logic [TW-1:0]    hm_rdata_reg;
    logic [TW-1:0]    tm_ra, tm_wa;
    logic             tm_we;
    tword_t           tm_wd;
    logic [LW-1:0]    hm_ra, hm_wa;
    logic             hm_we;
    logic [TW-1:0]    hm_wd;

    lvl_upd_t         upd;
    scan_cmd_t        scan;
    scan_res_t        scan_res;
    logic [LW-1:0]    q_lvl;
    logic             q_bit;

    logic [LW-1:0]    np_sat;
    logic             tid_ok;
    logic [LW-1:0]    t_lvl;
    logic             same_ht;

    prrs_lvl_track #(
        .NUM_LEVELS(NUM_LEVELS)
    ) u_lvl_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (upd),
        .scan    (scan),
        .q_lvl   (q_lvl),
        .q_bit   (q_bit),
        .scan_res(scan_res)
    );

    // Saturate the requested level, check the thread number.
    assign np_sat = ((LW + 1)'(new_priority) >= (LW + 1)'(NUM_LEVELS)) ?
                    LW'(NUM_LEVELS - 1) : new_priority;
    assign tid_ok = ((TW + 1)'(tid_reg) < (TW + 1)'(NUM_THREADS));

    // Level of the addressed thread; a level never written reads as zero.
    assign t_lvl   = lvl_valid_reg[tid_reg] ? tm_rdata_reg.lvl : '0;
    assign same_ht = (tail_reg == h_reg);

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign current_thread = cur_thread_reg;
    assign current_level  = cur_level_reg;
    assign is_idle        = is_idle_reg;
    assign status         = status_out_reg;

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (tm_we)
        begin
            thread_mem[tm_wa] <= tm_wd;
        end
        tm_rdata_reg <= thread_mem[tm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (hm_we)
        begin
            head_mem[hm_wa] <= hm_wd;
        end
        hm_rdata_reg <= head_mem[hm_ra];
    end

    // Operation sequencer.
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        status_next     = status_reg;
        tid_next        = tid_reg;
        np_next         = np_reg;
        lv_next         = lv_reg;
        n_next          = n_reg;
        p_next          = p_reg;
        h_next          = h_reg;
        tail_next       = tail_reg;
        hw_next         = hw_reg;
        serving_next    = serving_reg;
        idle_next       = idle_reg;
        queued_next     = queued_reg;
        lvl_valid_next  = lvl_valid_reg;
        out_valid_next  = out_valid_reg;
        cur_thread_next = cur_thread_reg;
        cur_level_next  = cur_level_reg;
        is_idle_next    = is_idle_reg;
        status_out_next = status_out_reg;

        tm_ra = tid_reg;
        tm_we = 1'b0;
        tm_wa = tid_reg;
        tm_wd = '0;
        hm_ra = serving_reg;
        hm_we = 1'b0;
        hm_wa = lv_reg;
        hm_wd = '0;
        upd   = '0;
        scan  = '0;
        q_lvl = lv_reg;

        // A result beat leaves the output register.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                tm_ra = thread_id;
                if (in_valid)
                begin
                    func_next   = func_t'(func);
                    tid_next    = thread_id;
                    np_next     = np_sat;
                    status_next = ST_OK;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                n_next  = tm_rdata_reg.nxt;
                p_next  = tm_rdata_reg.prv;
                lv_next = t_lvl;
                if (func_reg == FN_TICK)
                begin
                    if (idle_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        tm_ra      = hm_rdata_reg;
                        state_next = S_TICK_WR;
                    end
                end
                else if (!tid_ok)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    unique case (func_reg)
                        FN_ACTIVATE:
                        begin
                            if (queued_reg[tid_reg])
                            begin
                                status_next = ST_DOUBLE;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_LI_START;
                            end
                        end
                        FN_SUSPEND:
                        begin
                            if (!queued_reg[tid_reg])
                            begin
                                status_next = ST_UNQUEUED;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_LO_START;
                            end
                        end
                        FN_SETPRI:
                        begin
                            if (queued_reg[tid_reg])
                            begin
                                state_next = S_LO_START;
                            end
                            else
                            begin
                                tm_we                   = 1'b1;
                                tm_wa                   = tid_reg;
                                tm_wd                   = '{lvl: np_reg,
                                                            nxt: tm_rdata_reg.nxt,
                                                            prv: tm_rdata_reg.prv};
                                lvl_valid_next[tid_reg] = 1'b1;
                                state_next              = S_FIN;
                            end
                        end
                        FN_TICK:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // Rotate the served level's head one step.
            S_TICK_WR:
            begin
                hm_we      = 1'b1;
                hm_wa      = serving_reg;
                hm_wd      = tm_rdata_reg.nxt;
                state_next = S_FIN;
            end

            // Unlink: a lone thread empties its level, otherwise fix the ring.
            S_LO_START:
            begin
                queued_next[tid_reg] = 1'b0;
                tm_ra                = p_reg;
                hm_ra                = lv_reg;
                if (n_reg == tid_reg)
                begin
                    upd.en  = 1'b1;
                    upd.lvl = LVL_MAX_W'(lv_reg);
                    upd.val = 1'b0;
                    if ((lv_reg == serving_reg) && !idle_reg)
                    begin
                        scan.start = 1'b1;
                        scan.from  = LVL_MAX_W'(serving_reg);
                        state_next = S_LO_SCAN;
                    end
                    else
                    begin
                        state_next = S_LO_DONE;
                    end
                end
                else
                begin
                    state_next = S_LO_HEAD;
                end
            end

            S_LO_HEAD:
            begin
                if (hm_rdata_reg == tid_reg)
                begin
                    hm_we = 1'b1;
                    hm_wa = lv_reg;
                    hm_wd = n_reg;
                end
                tm_we      = 1'b1;
                tm_wa      = p_reg;
                tm_wd      = '{lvl: tm_rdata_reg.lvl, nxt: n_reg, prv: tm_rdata_reg.prv};
                state_next = S_LO_RDN;
            end

            // Read the successor only after the predecessor write has landed.
            S_LO_RDN:
            begin
                tm_ra      = n_reg;
                state_next = S_LO_WRN;
            end

            S_LO_WRN:
            begin
                tm_we      = 1'b1;
                tm_wa      = n_reg;
                tm_wd      = '{lvl: tm_rdata_reg.lvl, nxt: tm_rdata_reg.nxt, prv: p_reg};
                state_next = S_LO_DONE;
            end

            S_LO_SCAN:
            begin
                if (scan_res.done)
                begin
                    if (scan_res.found)
                    begin
                        serving_next = LW'(scan_res.lvl);
                    end
                    else
                    begin
                        idle_next = 1'b1;
                    end
                    state_next = S_LO_DONE;
                end
            end

            S_LO_DONE:
            begin
                if (func_reg == FN_SETPRI)
                begin
                    lv_next    = np_reg;
                    state_next = S_LI_START;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // Link in at the tail; an empty level gets a ring of one.
            S_LI_START:
            begin
                hm_ra = lv_reg;
                if (!q_bit)
                begin
                    tm_we      = 1'b1;
                    tm_wa      = tid_reg;
                    tm_wd      = '{lvl: lv_reg, nxt: tid_reg, prv: tid_reg};
                    hm_we      = 1'b1;
                    hm_wa      = lv_reg;
                    hm_wd      = tid_reg;
                    upd.en     = 1'b1;
                    upd.lvl    = LVL_MAX_W'(lv_reg);
                    upd.val    = 1'b1;
                    state_next = S_LI_DONE;
                end
                else
                begin
                    state_next = S_LI_RDH;
                end
            end

            S_LI_RDH:
            begin
                h_next     = hm_rdata_reg;
                tm_ra      = hm_rdata_reg;
                state_next = S_LI_RDHW;
            end

            S_LI_RDHW:
            begin
                hw_next    = tm_rdata_reg;
                tail_next  = tm_rdata_reg.prv;
                tm_ra      = tm_rdata_reg.prv;
                state_next = S_LI_RDTW;
            end

            // Tail points forward to the new thread.
            S_LI_RDTW:
            begin
                tm_we      = 1'b1;
                tm_wa      = tail_reg;
                tm_wd      = '{lvl: tm_rdata_reg.lvl, nxt: tid_reg,
                               prv: same_ht ? tid_reg : tm_rdata_reg.prv};
                state_next = S_LI_WRH;
            end

            // Head points back to the new thread.
            S_LI_WRH:
            begin
                tm_we      = 1'b1;
                tm_wa      = h_reg;
                tm_wd      = '{lvl: hw_reg.lvl, nxt: same_ht ? tid_reg : hw_reg.nxt,
                               prv: tid_reg};
                state_next = S_LI_WRT;
            end

            S_LI_WRT:
            begin
                tm_we      = 1'b1;
                tm_wa      = tid_reg;
                tm_wd      = '{lvl: lv_reg, nxt: h_reg, prv: tail_reg};
                state_next = S_LI_DONE;
            end

            S_LI_DONE:
            begin
                queued_next[tid_reg]    = 1'b1;
                lvl_valid_next[tid_reg] = 1'b1;
                if (idle_reg || (lv_reg > serving_reg))
                begin
                    serving_next = lv_reg;
                end
                idle_next  = 1'b0;
                state_next = S_FIN;
            end

            // Fetch the served level's head for the result.
            S_FIN:
            begin
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    cur_thread_next = idle_reg ? '0 : hm_rdata_reg;
                    cur_level_next  = serving_reg;
                    is_idle_next    = idle_reg;
                    status_out_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            func_reg       <= FN_ACTIVATE;
            status_reg     <= ST_OK;
            tid_reg        <= '0;
            np_reg         <= '0;
            lv_reg         <= '0;
            n_reg          <= '0;
            p_reg          <= '0;
            h_reg          <= '0;
            tail_reg       <= '0;
            hw_reg         <= '0;
            serving_reg    <= '0;
            idle_reg       <= 1'b1;
            queued_reg     <= '0;
            lvl_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
            cur_thread_reg <= '0;
            cur_level_reg  <= '0;
            is_idle_reg    <= 1'b0;
            status_out_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            status_reg     <= status_next;
            tid_reg        <= tid_next;
            np_reg         <= np_next;
            lv_reg         <= lv_next;
            n_reg          <= n_next;
            p_reg          <= p_next;
            h_reg          <= h_next;
            tail_reg       <= tail_next;
            hw_reg         <= hw_next;
            serving_reg    <= serving_next;
            idle_reg       <= idle_next;
            queued_reg     <= queued_next;
            lvl_valid_reg  <= lvl_valid_next;
            out_valid_reg  <= out_valid_next;
            cur_thread_reg <= cur_thread_next;
            cur_level_reg  <= cur_level_next;
            is_idle_reg    <= is_idle_next;
            status_out_reg <= status_out_next;
        end
    end

`ifndef SYNTHESIS
    // An idle result never names a thread.
    a_idle_no_thread: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_idle |-> current_thread == '0)
        else $error("idle result carries a thread");

    // Between operations, idle means every level is empty.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && idle_reg |-> !scan_res.any)
        else $error("idle while a level is occupied");

    // The level search only finishes while the sequencer waits for it.
    a_scan_owner: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> state_reg == S_LO_SCAN)
        else $error("level search finished outside its wait state");
`endif

endmodule

### dv/tb_priority_round_robin_scheduler.sv
`timescale 1ns / 1ps

module tb_priority_round_robin_scheduler;
    import prrs_pkg::*;

    localparam int NT         = 16;
    localparam int NL         = 8;
    localparam int WDOG_LIMIT = 2000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 40;

    typedef struct {
        logic [3:0] thread;
        logic [2:0] level;
        logic       idle;
        status_t    st;
    } sched_result_t;

    // Clock, reset and block ports.
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [1:0] func         = FN_TICK;
    logic [3:0] thread_id    = '0;
    logic [2:0] new_priority = '0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [3:0] current_thread;
    logic [2:0] current_level;
    logic       is_idle;
    logic [1:0] status;

    // Scheduler image kept by the testbench.
    int ring_next[NT]  = '{default: 0};
    int ring_prev[NT]  = '{default: 0};
    int ring_head[NL]  = '{default: 0};
    bit lvl_busy[NL]   = '{default: 0};
    int thr_level[NT]  = '{default: 0};
    bit thr_queued[NT] = '{default: 0};
    int serve_lvl      = 0;
    bit sched_idle     = 1'b1;

    sched_result_t pending_results[$];

    int err_cnt    = 0;
    int stall_cyc  = 0;
    int hold_left  = 0;
    bit hold_start = 1'b0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    priority_round_robin_scheduler u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .thread_id      (thread_id),
        .new_priority   (new_priority),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .current_thread (current_thread),
        .current_level  (current_level),
        .is_idle        (is_idle),
        .status         (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Append a thread at the tail of its level ring and raise the served level.
    function automatic void ring_insert(int t);
        int lv;
        int h;
        int tl;
        lv = thr_level[t];
        if (!lvl_busy[lv])
        begin
            ring_head[lv] = t;
            ring_next[t]  = t;
            ring_prev[t]  = t;
            lvl_busy[lv]  = 1'b1;
        end
        else
        begin
            h             = ring_head[lv];
            tl            = ring_prev[h];
            ring_next[tl] = t;
            ring_prev[t]  = tl;
            ring_next[t]  = h;
            ring_prev[h]  = t;
        end
        thr_queued[t] = 1'b1;
        if (sched_idle || lv > serve_lvl)
            serve_lvl = lv;
        sched_idle = 1'b0;
    endfunction

    // Unlink a thread. An emptied served level drops service to the next
    // non-empty level below it, or to idle when none is left.
    function automatic void ring_remove(int t);
        int lv;
        int n;
        int p;
        bit found;
        lv = thr_level[t];
        n  = ring_next[t];
        p  = ring_prev[t];
        thr_queued[t] = 1'b0;
        if (n == t)
        begin
            lvl_busy[lv] = 1'b0;
            if (lv == serve_lvl && !sched_idle)
            begin
                found = 1'b0;
                for (int i = serve_lvl - 1; i >= 0; i--)
                begin
                    if (!found && lvl_busy[i])
                    begin
                        serve_lvl = i;
                        found     = 1'b1;
                    end
                end
                if (!found)
                    sched_idle = 1'b1;
            end
        end
        else
        begin
            if (ring_head[lv] == t)
                ring_head[lv] = n;
            ring_next[p] = n;
            ring_prev[n] = p;
        end
    endfunction

    // Apply one operation to the image and return the result beat it produces.
    function automatic sched_result_t sched_step(func_t f, int t, int np);
        sched_result_t r;
        r.st = ST_OK;
        case (f)
            FN_ACTIVATE:
            begin
                if (thr_queued[t])
                    r.st = ST_DOUBLE;
                else
                    ring_insert(t);
            end
            FN_SUSPEND:
            begin
                if (!thr_queued[t])
                    r.st = ST_UNQUEUED;
                else
                    ring_remove(t);
            end
            FN_TICK:
            begin
                if (!sched_idle)
                    ring_head[serve_lvl] = ring_next[ring_head[serve_lvl]];
            end
            default:
            begin
                if (thr_queued[t])
                begin
                    ring_remove(t);
                    thr_level[t] = np;
                    ring_insert(t);
                end
                else
                begin
                    thr_level[t] = np;
                end
            end
        endcase
        r.thread = sched_idle ? 4'd0 : 4'(ring_head[serve_lvl]);
        r.level  = 3'(serve_lvl);
        r.idle   = sched_idle;
        return r;
    endfunction

    // Offer one input beat, wait until it is taken and record its expected result.
    task automatic send_op(func_t f, int t, int np);
        if (tx_idle_en && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        thread_id    <= 4'(t);
        new_priority <= 3'(np);
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(sched_step(f, t, np));
    endtask

    // Lower valid after the last beat of a sequence so it is not taken twice.
    task automatic stop_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Pick a thread that is queued or not, as asked, falling back to any thread.
    function automatic int pick_thread(bit want_queued);
        int t;
        for (int i = 0; i < 16; i++)
        begin
            t = $urandom_range(NT - 1);
            if (thr_queued[t] == want_queued)
                return t;
        end
        return t;
    endfunction

    // One random operation, mostly consistent with the current queue state.
    task automatic send_random(int act_w);
        int    r;
        int    t;
        int    np;
        func_t f;
        r  = $urandom_range(99);
        np = $urandom_range(NL - 1);
        if (r < act_w)
        begin
            f = FN_ACTIVATE;
            t = pick_thread(1'b0);
        end
        else if (r < act_w + 25)
        begin
            f = FN_SUSPEND;
            t = pick_thread(1'b1);
        end
        else if (r < act_w + 35)
        begin
            f = FN_TICK;
            t = $urandom_range(NT - 1);
        end
        else
        begin
            f = FN_SETPRI;
            t = pick_thread($urandom_range(3) != 0);
        end
        // Some noise: an arbitrary thread whatever its state.
        if ($urandom_range(9) == 0)
            t = $urandom_range(NT - 1);
        send_op(f, t, np);
    endtask

    // Round robin inside a single level, with the lowest and highest thread ids.
    task automatic test_ring_basics();
        send_op(FN_ACTIVATE, 0, 0);
        send_op(FN_TICK, 9, 7);
        send_op(FN_ACTIVATE, 15, 0);
        send_op(FN_TICK, 0, 0);
        send_op(FN_TICK, 15, 7);
    endtask

    // Double activate and suspend of a thread that is not queued.
    task automatic test_error_status();
        send_op(FN_ACTIVATE, 0, 0);
        send_op(FN_SUSPEND, 5, 0);
    endtask

    // Level rise, relinking, head removal on served and unserved levels, idle.
    task automatic test_level_changes();
        send_op(FN_SETPRI, 5, 7);
        send_op(FN_ACTIVATE, 5, 0);
        send_op(FN_SETPRI, 15, 7);
        send_op(FN_TICK, 0, 0);
        send_op(FN_SUSPEND, 5, 0);
        send_op(FN_SUSPEND, 15, 0);
        send_op(FN_SETPRI, 0, 3);
        send_op(FN_SUSPEND, 0, 0);
        send_op(FN_TICK, 0, 0);
        send_op(FN_ACTIVATE, 1, 0);
        send_op(FN_ACTIVATE, 2, 0);
        send_op(FN_SETPRI, 3, 5);
        send_op(FN_ACTIVATE, 3, 0);
        send_op(FN_SUSPEND, 1, 0);
        send_op(FN_SUSPEND, 3, 0);
    endtask

    // Receiver holds off for a long stretch while beats keep being offered.
    task automatic test_backpressure();
        stop_input();
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (int i = 0; i < 12; i++)
            send_random(45);
    endtask

    // Long random run alternating fill-up and drain phases.
    task automatic test_random_mix();
        for (int n = 0; n < 650; n++)
        begin
            if (n == 200)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            if (n == 380)
            begin
                tx_idle_en = 1'b1;
                rx_idle_en = 1'b1;
            end
            send_random(((n / 60) % 2 == 0) ? 55 : 25);
        end
    endtask

    // Result checking and receiver stall generation.
    always @(posedge clk)
    begin
        sched_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, thread %0d level %0d idle %0d status %0d",
                         $time, current_thread, current_level, is_idle, status);
                err_cnt++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (current_thread !== exp_r.thread)
                begin
                    $display("%0t: current_thread expected %0d actual %0d",
                             $time, exp_r.thread, current_thread);
                    err_cnt++;
                end
                if (current_level !== exp_r.level)
                begin
                    $display("%0t: current_level expected %0d actual %0d",
                             $time, exp_r.level, current_level);
                    err_cnt++;
                end
                if (is_idle !== exp_r.idle)
                begin
                    $display("%0t: is_idle expected %0d actual %0d",
                             $time, exp_r.idle, is_idle);
                    err_cnt++;
                end
                if (status !== exp_r.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.st, status);
                    err_cnt++;
                end
            end
        end
        if (hold_start)
        begin
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= rx_idle_en && ($urandom_range(99) < 13);
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            stall_cyc <= 0;
        else
            stall_cyc <= stall_cyc + 1;
        if (stall_cyc >= WDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ring_basics();
        test_error_status();
        test_level_changes();
        test_backpressure();
        test_random_mix();
        stop_input();

        // Drain outstanding results, then keep watching for stray result beats.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
